>>> rtl/pchk_pkg.sv
// Package with constants and types shared by the program-counter histogram.
`default_nettype none
package pchk_pkg;

  localparam int unsigned SLOTS = 8192;
  localparam int unsigned SLOT_W = $clog2(SLOTS);
  localparam int unsigned CNT_W = 32;
  localparam int unsigned ADDR_W = 32;
  localparam int unsigned TOP_W = 5;

  localparam logic [ADDR_W-1:0] BASE_RESET = 32'h0000_8000;
  localparam logic [TOP_W-1:0] TOP_RESET = 5'd12;
  localparam logic [TOP_W-1:0] MAX_ROUNDS = 5'd16;

  typedef enum logic {
    OP_COUNT  = 1'b0,
    OP_REPORT = 1'b1
  } op_e;

  typedef enum logic {
    CFG_BASE_ADDRESS = 1'b0,
    CFG_TOP_COUNT    = 1'b1
  } cfg_idx_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CNT_WR,
    ST_SCAN,
    ST_EVAL,
    ST_FLUSH
  } state_e;

endpackage
`default_nettype wire

>>> rtl/pchk_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module pchk_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule
`default_nettype wire

>>> rtl/pc_histogram_top_k.sv
// Top level of the program-counter profiling histogram with top-k report.
// A count beat inside the table takes a RAM read in ST_IDLE, then the incremented write-back in ST_CNT_WR.
// A count beat outside the table is dropped without leaving ST_IDLE.
// A report beat runs up to R rounds, R being top_count held to 1..16:
// each round is one full pass of the shared compare unit over the RAM read port plus
// an evaluate state, ST_EVAL. Results appear as one-cycle strobes; the receiver cannot stall them.
// After reset the block clears all SLOTS counters, one per cycle, with busy high.
`default_nettype none
module pc_histogram_top_k (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           op_i,
  input  wire logic [pchk_pkg::ADDR_W-1:0]    pc_value_i,
  input  wire logic                           cfg_we_i,
  input  wire logic                           cfg_idx_i,
  input  wire logic [pchk_pkg::ADDR_W-1:0]    cfg_data_i,
  output logic                                result_valid_o,
  output logic      [pchk_pkg::ADDR_W-1:0]    slot_pc_o,
  output logic      [pchk_pkg::CNT_W-1:0]     slot_count_o,
  output logic                                last_o
);

  import pchk_pkg::*;

  state_e state_q, state_d;

  logic [ADDR_W-1:0] base_q;
  logic [TOP_W-1:0]  top_q;

  logic [SLOT_W:0]   scan_q, scan_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CNT_W-1:0]  best_q, best_d;
  logic [SLOT_W-1:0] best_idx_q, best_idx_d;
  logic [TOP_W-1:0]  round_q, round_d;
  logic [TOP_W-1:0]  rounds_q, rounds_d;
  logic              pend_vld_q, pend_vld_d;
  logic [ADDR_W-1:0] pend_pc_q, pend_pc_d;
  logic [CNT_W-1:0]  pend_cnt_q, pend_cnt_d;
  logic              res_vld_q, res_vld_d;
  logic [ADDR_W-1:0] res_pc_q, res_pc_d;
  logic [CNT_W-1:0]  res_cnt_q, res_cnt_d;
  logic              res_last_q, res_last_d;

  logic              accept;
  logic [ADDR_W-1:0] diff;
  logic              in_range;
  logic [SLOT_W-1:0] in_idx;
  logic [SLOT_W-1:0] cmp_idx;
  logic              best_nz;
  logic              final_round;
  logic [TOP_W-1:0]  eff_rounds;

  logic              ram_we;
  logic [SLOT_W-1:0] ram_waddr;
  logic [CNT_W-1:0]  ram_wdata;
  logic [SLOT_W-1:0] ram_raddr;
  logic [CNT_W-1:0]  ram_rdata;

  assign busy        = (state_q != ST_IDLE);
  assign accept      = start && !busy;
  assign diff        = pc_value_i - base_q;
  assign in_range    = (pc_value_i >= base_q) && (diff[ADDR_W-1:2] < (ADDR_W-2)'(SLOTS));
  assign in_idx      = diff[SLOT_W+1:2];
  assign cmp_idx     = SLOT_W'(scan_q - 1'b1);
  assign best_nz     = (best_q != '0);
  assign final_round = (TOP_W'(round_q + 1'b1) == rounds_q);

  always_comb begin
    if (top_q == '0) begin
      eff_rounds = TOP_W'(1);
    end else if (top_q > MAX_ROUNDS) begin
      eff_rounds = MAX_ROUNDS;
    end else begin
      eff_rounds = top_q;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (scan_q == (SLOT_W+1)'(SLOTS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          if (op_e'(op_i) == OP_REPORT) begin
            state_d = ST_SCAN;
          end else if (in_range) begin
            state_d = ST_CNT_WR;
          end
        end
      end
      ST_CNT_WR: state_d = ST_IDLE;
      ST_SCAN: begin
        if (scan_q == (SLOT_W+1)'(SLOTS)) begin
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        if (!best_nz) begin
          state_d = ST_IDLE;
        end else if (final_round) begin
          state_d = ST_FLUSH;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_FLUSH: state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    scan_d     = scan_q;
    idx_d      = idx_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    round_d    = round_q;
    rounds_d   = rounds_q;
    pend_vld_d = pend_vld_q;
    pend_pc_d  = pend_pc_q;
    pend_cnt_d = pend_cnt_q;
    res_vld_d  = 1'b0;
    res_pc_d   = res_pc_q;
    res_cnt_d  = res_cnt_q;
    res_last_d = res_last_q;
    ram_we     = 1'b0;
    ram_waddr  = idx_q;
    ram_wdata  = ram_rdata + 1'b1;
    ram_raddr  = scan_q[SLOT_W-1:0];
    unique case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = scan_q[SLOT_W-1:0];
        ram_wdata = '0;
        scan_d    = (SLOT_W+1)'(scan_q + 1'b1);
      end
      ST_IDLE: begin
        ram_raddr = in_idx;
        idx_d     = in_idx;
        scan_d    = '0;
        best_d    = '0;
        best_idx_d = '0;
        round_d   = '0;
        rounds_d  = eff_rounds;
        pend_vld_d = 1'b0;
      end
      ST_CNT_WR: begin
        ram_we = 1'b1;
      end
      ST_SCAN: begin
        scan_d = (SLOT_W+1)'(scan_q + 1'b1);
        if ((scan_q != '0) && (ram_rdata > best_q)) begin
          best_d     = ram_rdata;
          best_idx_d = cmp_idx;
        end
      end
      ST_EVAL: begin
        scan_d     = '0;
        best_d     = '0;
        best_idx_d = '0;
        if (best_nz) begin
          res_vld_d  = pend_vld_q;
          res_pc_d   = pend_pc_q;
          res_cnt_d  = pend_cnt_q;
          res_last_d = 1'b0;
          pend_vld_d = 1'b1;
          pend_pc_d  = base_q + ADDR_W'({best_idx_q, 2'b00});
          pend_cnt_d = best_q;
          round_d    = TOP_W'(round_q + 1'b1);
          ram_we     = 1'b1;
          ram_waddr  = best_idx_q;
          ram_wdata  = '0;
        end else begin
          res_vld_d  = 1'b1;
          res_pc_d   = pend_vld_q ? pend_pc_q : '0;
          res_cnt_d  = pend_vld_q ? pend_cnt_q : '0;
          res_last_d = 1'b1;
          pend_vld_d = 1'b0;
        end
      end
      ST_FLUSH: begin
        res_vld_d  = 1'b1;
        res_pc_d   = pend_pc_q;
        res_cnt_d  = pend_cnt_q;
        res_last_d = 1'b1;
        pend_vld_d = 1'b0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_CLEAR;
      scan_q     <= '0;
      round_q    <= '0;
      rounds_q   <= TOP_W'(1);
      pend_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
      base_q     <= BASE_RESET;
      top_q      <= TOP_RESET;
    end else begin
      state_q    <= state_d;
      scan_q     <= scan_d;
      round_q    <= round_d;
      rounds_q   <= rounds_d;
      pend_vld_q <= pend_vld_d;
      res_vld_q  <= res_vld_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_e'(cfg_idx_i))
          CFG_BASE_ADDRESS: base_q <= cfg_data_i;
          CFG_TOP_COUNT:    top_q  <= cfg_data_i[TOP_W-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q      <= idx_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    pend_pc_q  <= pend_pc_d;
    pend_cnt_q <= pend_cnt_d;
    res_pc_q   <= res_pc_d;
    res_cnt_q  <= res_cnt_d;
    res_last_q <= res_last_d;
  end

  pchk_ram #(
    .WIDTH(CNT_W),
    .DEPTH(SLOTS)
  ) u_counts (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  assign result_valid_o = res_vld_q;
  assign slot_pc_o      = res_pc_q;
  assign slot_count_o   = res_cnt_q;
  assign last_o         = res_last_q;

  a_nonlast_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_o |-> (state_q == ST_SCAN) || (state_q == ST_FLUSH))
    else $error("non-final beat emitted while the report is not continuing");

  a_zero_count_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && (slot_count_o == '0) |-> last_o)
    else $error("zero count beat without last flag");

  a_count_write_follows_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CNT_WR) |-> $past(start && !busy))
    else $error("counter write-back without an accepted count beat");

  a_rounds_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (round_q < rounds_q) && (rounds_q <= MAX_ROUNDS))
    else $error("report round count out of bounds");

endmodule
`default_nettype wire

>>> test/tb_pc_histogram_top_k.sv
// Self-checking testbench for the program-counter histogram with its top-k slot report.
`timescale 1ns / 100ps
module tb_pc_histogram_top_k;
  import pchk_pkg::*;

  typedef struct {
    logic        drain;
    op_e         op;
    logic [31:0] pc;
  } beat_t;

  typedef struct {
    logic [31:0] pc;
    logic [31:0] cnt;
    logic        last;
  } slot_rec_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        op_i = OP_COUNT;
  logic [31:0] pc_value_i = '0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_idx_i = CFG_BASE_ADDRESS;
  logic [31:0] cfg_data_i = '0;
  logic        result_valid_o;
  logic [31:0] slot_pc_o;
  logic [31:0] slot_count_o;
  logic        last_o;

  logic [31:0] tally [SLOTS];
  logic [31:0] cov_base;
  logic [4:0]  rank_limit;
  slot_rec_t   top_slots_due [$];
  beat_t       beat_fifo [$];
  beat_t       next_beat;
  logic        took;
  int          idle_pct = 30;
  int          errors = 0;
  int          beats_sent = 0;
  int          reports_sent = 0;
  int          results_seen = 0;
  int          settings_used = 0;
  longint      cycles = 0;
  longint      budget = 0;

  pc_histogram_top_k DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .op_i          (op_i),
    .pc_value_i    (pc_value_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .result_valid_o(result_valid_o),
    .slot_pc_o     (slot_pc_o),
    .slot_count_o  (slot_count_o),
    .last_o        (last_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) cycles <= cycles + 1;

  task automatic report_error(input string what, input logic [31:0] got,
                              input logic [31:0] want);
    errors++;
    if (errors <= 40) begin
      $display("ERROR at cycle %0d: %s got %h, want %h", cycles, what, got, want);
    end
  endtask

  function automatic void apply_beat(op_e op, logic [31:0] pc);
    logic [31:0] off;
    logic [31:0] best;
    int unsigned best_i;
    int unsigned rounds;
    int          n;
    slot_rec_t   rec;
    if (op == OP_COUNT) begin
      if (pc >= cov_base) begin
        off = (pc - cov_base) >> 2;
        if (off < SLOTS) tally[off] = tally[off] + 1;
      end
      return;
    end
    if (rank_limit == 0) rounds = 1;
    else if (rank_limit > MAX_ROUNDS) rounds = MAX_ROUNDS;
    else rounds = rank_limit;
    n = 0;
    for (int r = 0; r < rounds; r++) begin
      best = '0;
      best_i = 0;
      for (int i = 0; i < SLOTS; i++) begin
        if (tally[i] > best) begin
          best = tally[i];
          best_i = i;
        end
      end
      if (best == 0) break;
      rec.pc = cov_base + 32'(best_i << 2);
      rec.cnt = best;
      rec.last = 1'b0;
      tally[best_i] = '0;
      top_slots_due.push_back(rec);
      n++;
    end
    if (n == 0) begin
      rec.pc = '0;
      rec.cnt = '0;
      rec.last = 1'b1;
      top_slots_due.push_back(rec);
    end else begin
      top_slots_due[top_slots_due.size() - 1].last = 1'b1;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      op_i <= OP_COUNT;
      pc_value_i <= '0;
    end else begin
      took = start && !busy;
      if (took) begin
        apply_beat(op_e'(op_i), pc_value_i);
        beats_sent++;
        if (op_i == OP_REPORT) reports_sent++;
      end
      if (took || !start) begin
        while (beat_fifo.size() > 0 && beat_fifo[0].drain && top_slots_due.size() == 0) begin
          void'(beat_fifo.pop_front());
        end
        if (beat_fifo.size() > 0 && !beat_fifo[0].drain &&
            $urandom_range(0, 99) >= idle_pct) begin
          next_beat = beat_fifo.pop_front();
          start <= 1'b1;
          op_i <= next_beat.op;
          pc_value_i <= next_beat.pc;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (top_slots_due.size() == 0) begin
        report_error("unexpected result, slot_pc", slot_pc_o, '0);
      end else begin
        slot_rec_t w;
        w = top_slots_due.pop_front();
        results_seen++;
        if (slot_pc_o !== w.pc) report_error("slot_pc", slot_pc_o, w.pc);
        if (slot_count_o !== w.cnt) report_error("slot_count", slot_count_o, w.cnt);
        if (last_o !== w.last) report_error("last", 32'(last_o), 32'(w.last));
      end
    end
  end

  task automatic push_beat(input op_e op, input logic [31:0] pc);
    beat_t b;
    b.drain = 1'b0;
    b.op = op;
    b.pc = pc;
    beat_fifo.push_back(b);
    if (op == OP_REPORT) budget += MAX_ROUNDS * (SLOTS + 2) + 40;
    else budget += 40;
  endtask

  task automatic push_drain();
    beat_t b;
    b.drain = 1'b1;
    b.op = OP_COUNT;
    b.pc = '0;
    beat_fifo.push_back(b);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    if (idx == CFG_BASE_ADDRESS) cov_base = data;
    else rank_limit = data[4:0];
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_config(input logic [31:0] base, input logic [4:0] rounds);
    logic [31:0] d;
    d = $urandom();
    d[4:0] = rounds;
    write_reg(CFG_BASE_ADDRESS, base);
    write_reg(CFG_TOP_COUNT, d);
    settings_used++;
  endtask

  task automatic wait_quiet();
    do @(negedge clk_i);
    while (beat_fifo.size() != 0 || start || top_slots_due.size() != 0);
    repeat (4) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  function automatic logic [31:0] hot_pc(bit spread);
    int unsigned idx;
    if (spread) idx = $urandom_range(0, SLOTS - 1);
    else begin
      case ($urandom_range(0, 9))
        0:       idx = $urandom_range(0, SLOTS - 1);
        1:       idx = SLOTS - 1;
        default: idx = $urandom_range(0, 7);
      endcase
    end
    return cov_base + 32'(idx << 2) + 32'($urandom_range(0, 3));
  endfunction

  task automatic fill_random(input int n, input bit spread, input bit close_with_report);
    int          made;
    int          roll;
    logic [31:0] pc;
    made = 0;
    while (made < n) begin
      roll = $urandom_range(0, 99);
      if (!spread && roll < 3) begin
        push_beat(OP_REPORT, $urandom());
        if ($urandom_range(0, 1)) push_drain();
        made++;
      end else if (roll < 13) begin
        if ($urandom_range(0, 1) || cov_base < 64) pc = $urandom();
        else pc = cov_base - 32'($urandom_range(1, 64));
        push_beat(OP_COUNT, pc);
      end else begin
        push_beat(OP_COUNT, hot_pc(spread));
        made++;
      end
    end
    if (close_with_report) begin
      push_beat(OP_REPORT, $urandom());
      push_drain();
    end
  endtask

  initial begin
    for (int i = 0; i < SLOTS; i++) tally[i] = '0;
    cov_base = BASE_RESET;
    rank_limit = TOP_RESET;
    budget = 4 * SLOTS + 1000;

    push_beat(OP_REPORT, 32'h0000_8000);
    push_beat(OP_COUNT, 32'h0000_8000);
    push_beat(OP_COUNT, 32'h0000_8003);
    push_beat(OP_COUNT, 32'h0000_7FFF);
    push_beat(OP_COUNT, 32'h0000_0000);
    push_beat(OP_COUNT, 32'h0000_8000 + 32'(4 * SLOTS) - 1);
    push_beat(OP_COUNT, 32'h0000_8000 + 32'(4 * SLOTS));
    push_beat(OP_COUNT, 32'hFFFF_FFFF);
    push_beat(OP_REPORT, 32'hFFFF_FFFF);
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    wait_quiet();

    set_config(32'hFFFF_FFFC, 5'd0);
    push_beat(OP_COUNT, 32'hFFFF_FFFC);
    push_beat(OP_COUNT, 32'hFFFF_FFFF);
    push_beat(OP_COUNT, 32'hFFFF_FFFB);
    push_beat(OP_COUNT, 32'h0000_0000);
    push_beat(OP_REPORT, 32'h0000_0000);
    wait_quiet();

    set_config(32'h0000_0000, 5'd2);
    push_beat(OP_COUNT, 32'h0000_0000);
    push_beat(OP_COUNT, 32'h0000_0004);
    push_beat(OP_COUNT, 32'h0000_0004);
    push_beat(OP_COUNT, 32'h0000_0008);
    push_beat(OP_COUNT, 32'h0000_000B);
    push_beat(OP_REPORT, 32'h0000_0000);
    wait_quiet();

    set_config(32'h0000_1003, 5'd31);
    push_beat(OP_COUNT, 32'h0000_1003);
    push_beat(OP_COUNT, 32'h0000_1006);
    push_beat(OP_COUNT, 32'h0000_1007);
    push_beat(OP_COUNT, 32'h0000_1002);
    push_beat(OP_REPORT, 32'h0000_1003);
    wait_quiet();

    set_config($urandom_range(0, 32'hFFFF_0000) & 32'hFFFF_FFFC, 5'd16);
    fill_random(30, 1'b1, 1'b1);
    wait_quiet();

    set_config($urandom_range(0, 32'hFFFF_0000), 5'd4);
    fill_random(70, 1'b0, 1'b1);
    wait_quiet();

    idle_pct = 0;
    set_config(32'h0000_0000, 5'd3);
    fill_random(70, 1'b0, 1'b1);
    wait_quiet();

    idle_pct = 30;
    set_config(32'hFFFF_7FFC, 5'd1);
    fill_random(70, 1'b0, 1'b1);
    wait_quiet();

    set_config(BASE_RESET + 32'($urandom_range(0, 255)), 5'd5);
    fill_random(70, 1'b0, 1'b1);

    do @(negedge clk_i);
    while (beat_fifo.size() != 0 || start || top_slots_due.size() != 0);
    repeat (20) @(negedge clk_i);
    if (top_slots_due.size() != 0) begin
      report_error("results never arrived, count", 32'(top_slots_due.size()), '0);
    end

    $display("Sent %0d beats, %0d of them reports, across %0d register settings.",
             beats_sent, reports_sent, settings_used + 1);
    $display("Checked %0d reported slots against the predicted histogram.", results_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    @(posedge clk_i);
    while (cycles <= 4 * budget + 20000) @(posedge clk_i);
    $display("Timeout after %0d cycles", cycles);
    $display("Mismatches found");
    $finish;
  end

endmodule

>>> filelist.f
rtl/pchk_pkg.sv
rtl/pchk_ram.sv
rtl/pc_histogram_top_k.sv
test/tb_pc_histogram_top_k.sv
